FILE: src/launch_query_parser_core_assert.svh
// Assertion macros shared by the launch query parser modules.
`ifndef LAUNCH_QUERY_PARSER_CORE_ASSERT_SVH
`define LAUNCH_QUERY_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LQP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LQP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/lqp_pkg.sv
// Types, constants and match functions of the launch query parser.
`timescale 1ns / 1ps
`default_nettype none

package lqp_pkg;

   localparam int unsigned MaxResults        = 3;
   localparam int unsigned CountWidth        = $clog2(MaxResults + 1);
   localparam int unsigned QueueDepthDefault = 4;
   localparam int unsigned KeyCount          = 5;

   // item kinds
   localparam logic [1:0] KindStart  = 2'd0;
   localparam logic [1:0] KindData   = 2'd1;
   localparam logic [1:0] KindStatus = 2'd2;

   // end status codes
   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusBadScheme = 2'd1;
   localparam logic [1:0] StatusNoPlace   = 2'd2;
   localparam logic [1:0] StatusBadEscape = 2'd3;

   // field ids
   localparam logic [2:0] FieldPlace = 3'd0;
   localparam logic [2:0] NoField    = 3'd5;

   // characters
   localparam logic [7:0] ChPct   = 8'h25;
   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChAmp   = 8'h26;
   localparam logic [7:0] ChEq    = 8'h3D;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChDash  = 8'h2D;

   // scheme prefixes, right-aligned, first character in the highest used byte
   localparam logic [127:0] PrefixShort = 128'h726F626C6F783A2F2F;
   localparam logic [127:0] PrefixLong  = 128'h726F626C6F782D706C617965723A2F2F;
   localparam logic [4:0]   PrefixShortLen = 5'd9;
   localparam logic [4:0]   PrefixLongLen  = 5'd16;
   localparam logic [4:0]   PrefixPivot    = 5'd6;

   localparam logic [8*24-1:0] KeyName0 = "placeId";
   localparam logic [8*24-1:0] KeyName1 = "gameInstanceId";
   localparam logic [8*24-1:0] KeyName2 = "reservedServerAccessCode";
   localparam logic [8*24-1:0] KeyName3 = "launchData";
   localparam logic [8*24-1:0] KeyName4 = "callId";

   typedef struct packed {
      logic [7:0] uri_byte;
      logic       is_final;
   } req_word_type;

   typedef struct packed {
      logic [1:0] item_kind;
      logic [2:0] field_id;
      logic [7:0] data_byte;
      logic [1:0] status_code;
      logic       run_end;
   } rsp_word_type;

   typedef struct packed {
      rsp_word_type [MaxResults-1:0] items;
      logic [CountWidth-1:0]         count;
   } bundle_type;

   function automatic logic [4:0] prefix_len(input logic variant);
      prefix_len = variant ? PrefixLongLen : PrefixShortLen;
   endfunction

   function automatic logic prefix_hit(input logic variant, input logic [4:0] pos,
                                       input logic [7:0] c);
      logic [127:0] name;
      int unsigned  len;
      name = variant ? PrefixLong : PrefixShort;
      len  = int'(prefix_len(variant));
      prefix_hit = 1'b0;
      if (int'(pos) < len) prefix_hit = (name[8*(len - 1 - int'(pos)) +: 8] == c);
   endfunction

   function automatic logic [4:0] key_len(input logic [2:0] idx);
      unique case (idx)
         3'd0:    key_len = 5'd7;
         3'd1:    key_len = 5'd14;
         3'd2:    key_len = 5'd24;
         3'd3:    key_len = 5'd10;
         3'd4:    key_len = 5'd6;
         default: key_len = 5'd0;
      endcase
   endfunction

   function automatic logic key_hit(input logic [2:0] idx, input logic [4:0] pos,
                                    input logic [7:0] c);
      logic [8*24-1:0] name;
      int unsigned     len;
      unique case (idx)
         3'd0:    name = KeyName0;
         3'd1:    name = KeyName1;
         3'd2:    name = KeyName2;
         3'd3:    name = KeyName3;
         3'd4:    name = KeyName4;
         default: name = '0;
      endcase
      len = int'(key_len(idx));
      key_hit = 1'b0;
      if (int'(pos) < len) key_hit = (name[8*(len - 1 - int'(pos)) +: 8] == c);
   endfunction

   function automatic logic [KeyCount-1:0] key_feed(input logic [KeyCount-1:0] flags,
                                                    input logic [4:0] pos,
                                                    input logic [7:0] c);
      for (int i = 0; i < KeyCount; i++)
         key_feed[i] = flags[i] && key_hit(3'(i), pos, c);
   endfunction

   function automatic logic [4:0] key_len_inc(input logic [4:0] len);
      key_len_inc = (len == 5'd31) ? len : len + 5'd1;
   endfunction

   function automatic logic [2:0] key_select(input logic [KeyCount-1:0] flags,
                                             input logic [4:0] len);
      key_select = NoField;
      for (int i = 0; i < KeyCount; i++)
         if (flags[i] && len == key_len(3'(i))) key_select = 3'(i);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_nib(input logic [7:0] c);
      logic [7:0] v;
      if (c <= 8'h39)      v = c - 8'h30;
      else if (c >= 8'h61) v = c - 8'h57;
      else                 v = c - 8'h37;
      hex_nib = v[3:0];
   endfunction

   function automatic logic [7:0] plus_map(input logic [7:0] c);
      plus_map = (c == ChPlus) ? ChSpace : c;
   endfunction

   function automatic rsp_word_type make_item(input logic [1:0] kind, input logic [2:0] field,
                                              input logic [7:0] data, input logic [1:0] status);
      make_item = '{item_kind: kind, field_id: field, data_byte: data,
                    status_code: status, run_end: 1'b0};
   endfunction

endpackage

`default_nettype wire

FILE: src/launch_query_parser_core.sv
// Top level of the launch query parser.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  lqp_pkg::req_word_type (uri_byte, is_final)
//   rsp_     out        rsp_valid/rsp_stall  lqp_pkg::rsp_word_type (kind, field, data, status, run_end)
//
// One input word per cycle while the bundle queue has room; the front end
// decodes a byte combinationally, in the cycle it is taken.
// A byte that yields k result words (k up to 3) is unpacked word by word at the back end;
// the queue of QueueDepth bundles absorbs these bursts.
// First result word passes through the queue slot and then the output register before it is valid on rsp_.
// Reset is synchronous and immediate; there is no clearing pass.
// rsp_stall holds the output register; req_stall rises only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module launch_query_parser_core #(
   parameter int unsigned QueueDepth = lqp_pkg::QueueDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  lqp_pkg::req_word_type req_word,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output lqp_pkg::rsp_word_type rsp_word,
   input  logic                  rsp_stall
);

   logic                queue_full;
   logic                push;
   lqp_pkg::bundle_type push_bundle;
   logic                pop;
   logic                head_valid;
   lqp_pkg::bundle_type head_bundle;

   lqp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_word    (req_word),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   lqp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (queue_full),
      .head_valid  (head_valid),
      .head_bundle (head_bundle)
   );

   lqp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .rsp_stall   (rsp_stall)
   );

endmodule

`default_nettype wire

FILE: src/lqp_front.sv
// Front end: scheme check, pair splitting, escape decoding, key matching.
`timescale 1ns / 1ps
`default_nettype none
`include "launch_query_parser_core_assert.svh"

module lqp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  lqp_pkg::req_word_type req_word,
   output logic                 req_stall,
   input  logic                 queue_full,
   output logic                 push,
   output lqp_pkg::bundle_type  push_bundle
);

   typedef enum logic [1:0] {PhPrefix, PhKey, PhValue, PhReject} phase_type;

   localparam logic [1:0] EscNone = 2'd0;
   localparam logic [1:0] EscOne  = 2'd1;
   localparam logic [1:0] EscTwo  = 2'd2;

   phase_type                         phase_ff, phase_in;
   logic [4:0]                        pos_ff, pos_in;
   logic                              variant_ff, variant_in;
   logic [4:0]                        klen_ff, klen_in;
   logic [lqp_pkg::KeyCount-1:0]      kflags_ff, kflags_in;
   logic [2:0]                        field_ff, field_in;
   logic [1:0]                        escp_ff, escp_in;
   logic [7:0]                        escf_ff, escf_in;
   logic                              place_ff, place_in;
   logic                              err_ff, err_in;
   logic                              kbad_ff, kbad_in;

   logic                                        accept;
   logic [7:0]                                  byte_in;
   logic                                        fin_in;
   logic                                        prefix_ok;
   logic                                        flush_value;
   logic                                        new_pair;
   logic [1:0]                                  status;
   logic [lqp_pkg::CountWidth-1:0]              n_out;
   lqp_pkg::rsp_word_type [lqp_pkg::MaxResults-1:0] items_out;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign byte_in   = req_word.uri_byte;
   assign fin_in    = req_word.is_final;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      variant_in  = variant_ff;
      klen_in     = klen_ff;
      kflags_in   = kflags_ff;
      field_in    = field_ff;
      escp_in     = escp_ff;
      escf_in     = escf_ff;
      place_in    = place_ff;
      err_in      = err_ff;
      kbad_in     = kbad_ff;
      n_out       = '0;
      items_out   = '0;
      prefix_ok   = 1'b0;
      flush_value = 1'b0;
      new_pair    = 1'b0;
      status      = lqp_pkg::StatusOk;

      unique case (phase_ff)
         PhPrefix: begin
            if (pos_ff == lqp_pkg::PrefixPivot) begin
               if (byte_in == lqp_pkg::ChColon) begin
                  variant_in = 1'b0;
                  prefix_ok  = 1'b1;
               end else if (byte_in == lqp_pkg::ChDash) begin
                  variant_in = 1'b1;
                  prefix_ok  = 1'b1;
               end
            end else begin
               prefix_ok = lqp_pkg::prefix_hit(variant_ff, pos_ff, byte_in);
            end
            if (!prefix_ok) begin
               phase_in = PhReject;
            end else begin
               pos_in = pos_ff + 5'd1;
               if (pos_in >= lqp_pkg::prefix_len(variant_in)) new_pair = 1'b1;
            end
         end
         PhKey: begin
            if (byte_in == lqp_pkg::ChAmp) begin
               new_pair = 1'b1;
            end else if (byte_in == lqp_pkg::ChEq) begin
               // short escape at end of key is fed literally
               if (escp_ff != EscNone) begin
                  kflags_in = lqp_pkg::key_feed(kflags_in, klen_in, lqp_pkg::ChPct);
                  klen_in   = lqp_pkg::key_len_inc(klen_in);
               end
               if (escp_ff == EscTwo) begin
                  kflags_in = lqp_pkg::key_feed(kflags_in, klen_in,
                                                lqp_pkg::plus_map(escf_ff));
                  klen_in   = lqp_pkg::key_len_inc(klen_in);
               end
               if (kbad_ff) err_in = 1'b1;
               field_in = lqp_pkg::key_select(kflags_in, klen_in);
               if (field_in != lqp_pkg::NoField) begin
                  items_out[n_out] = lqp_pkg::make_item(lqp_pkg::KindStart, field_in, 8'h00,
                                                        lqp_pkg::StatusOk);
                  n_out = n_out + 2'd1;
                  if (field_in == lqp_pkg::FieldPlace) place_in = 1'b0;
               end
               phase_in = PhValue;
               escp_in  = EscNone;
               escf_in  = '0;
            end else if (escp_ff == EscNone) begin
               if (byte_in == lqp_pkg::ChPct) begin
                  escp_in = EscOne;
               end else begin
                  kflags_in = lqp_pkg::key_feed(kflags_ff, klen_ff, lqp_pkg::plus_map(byte_in));
                  klen_in   = lqp_pkg::key_len_inc(klen_ff);
               end
            end else if (escp_ff == EscOne) begin
               escf_in = byte_in;
               escp_in = EscTwo;
            end else begin
               if (lqp_pkg::is_hex(escf_ff) && lqp_pkg::is_hex(byte_in)) begin
                  kflags_in = lqp_pkg::key_feed(kflags_ff, klen_ff,
                                 {lqp_pkg::hex_nib(escf_ff), lqp_pkg::hex_nib(byte_in)});
                  klen_in   = lqp_pkg::key_len_inc(klen_ff);
               end else begin
                  kbad_in = 1'b1;
               end
               escp_in = EscNone;
               escf_in = '0;
            end
         end
         PhValue: begin
            if (byte_in == lqp_pkg::ChAmp) begin
               flush_value = 1'b1;
               new_pair    = 1'b1;
            end else if (escp_ff == EscNone) begin
               if (byte_in == lqp_pkg::ChPct) begin
                  escp_in = EscOne;
               end else if (field_ff != lqp_pkg::NoField) begin
                  items_out[n_out] = lqp_pkg::make_item(lqp_pkg::KindData, field_ff,
                                        lqp_pkg::plus_map(byte_in), lqp_pkg::StatusOk);
                  n_out = n_out + 2'd1;
                  if (field_ff == lqp_pkg::FieldPlace) place_in = 1'b1;
               end
            end else if (escp_ff == EscOne) begin
               escf_in = byte_in;
               escp_in = EscTwo;
            end else begin
               if (lqp_pkg::is_hex(escf_ff) && lqp_pkg::is_hex(byte_in)) begin
                  if (field_ff != lqp_pkg::NoField) begin
                     items_out[n_out] = lqp_pkg::make_item(lqp_pkg::KindData, field_ff,
                                           {lqp_pkg::hex_nib(escf_ff), lqp_pkg::hex_nib(byte_in)},
                                           lqp_pkg::StatusOk);
                     n_out = n_out + 2'd1;
                     if (field_ff == lqp_pkg::FieldPlace) place_in = 1'b1;
                  end
               end else begin
                  err_in = 1'b1;
               end
               escp_in = EscNone;
               escf_in = '0;
            end
         end
         PhReject: begin
         end
      endcase

      if (fin_in && phase_in == PhValue) flush_value = 1'b1;

      // pending escape at end of value goes out literally
      if (flush_value) begin
         if (escp_in != EscNone && field_in != lqp_pkg::NoField) begin
            items_out[n_out] = lqp_pkg::make_item(lqp_pkg::KindData, field_in, lqp_pkg::ChPct,
                                                  lqp_pkg::StatusOk);
            n_out = n_out + 2'd1;
            if (field_in == lqp_pkg::FieldPlace) place_in = 1'b1;
         end
         if (escp_in == EscTwo && field_in != lqp_pkg::NoField) begin
            items_out[n_out] = lqp_pkg::make_item(lqp_pkg::KindData, field_in,
                                                  lqp_pkg::plus_map(escf_in), lqp_pkg::StatusOk);
            n_out = n_out + 2'd1;
         end
         escp_in = EscNone;
         escf_in = '0;
      end

      if (new_pair) begin
         phase_in  = PhKey;
         klen_in   = '0;
         kflags_in = '1;
         field_in  = lqp_pkg::NoField;
         escp_in   = EscNone;
         escf_in   = '0;
         kbad_in   = 1'b0;
      end

      if (fin_in) begin
         if (phase_in == PhPrefix || phase_in == PhReject) status = lqp_pkg::StatusBadScheme;
         else if (err_in)                                 status = lqp_pkg::StatusBadEscape;
         else if (!place_in)                              status = lqp_pkg::StatusNoPlace;
         else                                             status = lqp_pkg::StatusOk;
         items_out[n_out] = lqp_pkg::make_item(lqp_pkg::KindStatus, 3'd0, 8'h00, status);
         n_out = n_out + 2'd1;
         phase_in   = PhPrefix;
         pos_in     = '0;
         variant_in = 1'b0;
         klen_in    = '0;
         kflags_in  = '1;
         field_in   = lqp_pkg::NoField;
         escp_in    = EscNone;
         escf_in    = '0;
         place_in   = 1'b0;
         err_in     = 1'b0;
         kbad_in    = 1'b0;
      end

      if (n_out != '0) items_out[n_out - 2'd1].run_end = 1'b1;
   end

   assign push        = accept && (n_out != '0);
   assign push_bundle = '{items: items_out, count: n_out};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhPrefix;
         pos_ff     <= '0;
         variant_ff <= 1'b0;
         klen_ff    <= '0;
         kflags_ff  <= '1;
         field_ff   <= lqp_pkg::NoField;
         escp_ff    <= EscNone;
         escf_ff    <= '0;
         place_ff   <= 1'b0;
         err_ff     <= 1'b0;
         kbad_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         variant_ff <= variant_in;
         klen_ff    <= klen_in;
         kflags_ff  <= kflags_in;
         field_ff   <= field_in;
         escp_ff    <= escp_in;
         escf_ff    <= escf_in;
         place_ff   <= place_in;
         err_ff     <= err_in;
         kbad_ff    <= kbad_in;
      end
   end

   `LQP_ASSERT_NOW(f_final_pushes, clock, reset, accept && fin_in, push, "final word gave no status")

endmodule

`default_nettype wire

FILE: src/lqp_queue.sv
// Short queue of result bundles between front and back.
`timescale 1ns / 1ps
`default_nettype none
`include "launch_query_parser_core_assert.svh"

module lqp_queue #(
   parameter int unsigned Depth = lqp_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lqp_pkg::bundle_type push_bundle,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output lqp_pkg::bundle_type head_bundle
);

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   lqp_pkg::bundle_type slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full        = (count_ff == CntW'(Depth));
   assign head_valid  = (count_ff != '0);
   assign head_bundle = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_bundle;
   end

   `LQP_ASSERT_NOW(q_no_overflow, clock, reset, push, !full, "push into full queue")
   `LQP_ASSERT_NEXT(q_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "count did not rise")

endmodule

`default_nettype wire

FILE: src/lqp_back.sv
// Back end: unpacks bundles into single result words behind an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "launch_query_parser_core_assert.svh"

module lqp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  lqp_pkg::bundle_type   head_bundle,
   output logic                  pop,
   output logic                  rsp_valid,
   output lqp_pkg::rsp_word_type rsp_word,
   input  logic                  rsp_stall
);

   logic                               rsp_valid_ff, rsp_valid_in;
   lqp_pkg::rsp_word_type              rsp_word_ff, rsp_word_in;
   logic [lqp_pkg::CountWidth-1:0]     idx_ff, idx_in;
   logic                               room;
   logic                               load;
   logic                               last;

   assign room = !rsp_valid_ff || !rsp_stall;
   assign load = head_valid && room;
   assign last = (idx_ff == head_bundle.count - 2'd1);
   assign pop  = load && last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      idx_in       = idx_ff;
      if (room) begin
         rsp_valid_in = head_valid;
         if (head_valid) rsp_word_in = head_bundle.items[idx_ff];
      end
      if (load) idx_in = last ? '0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `LQP_ASSERT_NOW(b_idx_in_range, clock, reset, head_valid, idx_ff < head_bundle.count, "index past bundle")
   `LQP_ASSERT_NOW(b_status_last, clock, reset, rsp_valid_ff && rsp_word_ff.item_kind == lqp_pkg::KindStatus, rsp_word_ff.run_end, "status word not last")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the launch query parser: random and directed URIs.
`timescale 1ns / 1ps

module testbench;
   import lqp_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int RandomBytes = 310;

   typedef enum logic [1:0] {PH_SCHEME, PH_KEY, PH_VALUE, PH_REJECT} parse_phase_e;

   class query_scoreboard;
      parse_phase_e phase;
      logic [4:0]   spos;
      logic         variant;
      logic [4:0]   klen;
      logic [4:0]   kflags;
      logic [2:0]   field;
      logic [1:0]   esc_state;
      logic [7:0]   esc_first;
      logic         place_filled;
      logic [1:0]   err;
      logic         key_bad;
      rsp_word_type burst[$];
      rsp_word_type due_words[$];
      int           mismatches;

      function new();
         mismatches = 0;
         clear_state();
      endfunction

      function int scheme_len(int v);
         return v ? int'(PrefixLongLen) : int'(PrefixShortLen);
      endfunction

      function logic [7:0] scheme_char(int v, int pos);
         logic [127:0] name;
         name = v ? PrefixLong : PrefixShort;
         return name[8*(scheme_len(v) - 1 - pos) +: 8];
      endfunction

      function int key_size(int idx);
         case (idx)
            0: return 7;
            1: return 14;
            2: return 24;
            3: return 10;
            default: return 6;
         endcase
      endfunction

      function logic [7:0] key_char(int idx, int pos);
         logic [8*24-1:0] name;
         case (idx)
            0: name = KeyName0;
            1: name = KeyName1;
            2: name = KeyName2;
            3: name = KeyName3;
            default: name = KeyName4;
         endcase
         return name[8*(key_size(idx) - 1 - pos) +: 8];
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
         if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
         if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
         return -1;
      endfunction

      function void start_pair();
         phase     = PH_KEY;
         klen      = '0;
         kflags    = '1;
         field     = NoField;
         esc_state = '0;
         esc_first = '0;
         key_bad   = 1'b0;
      endfunction

      function void clear_state();
         start_pair();
         phase        = PH_SCHEME;
         spos         = '0;
         variant      = 1'b0;
         place_filled = 1'b0;
         err          = StatusOk;
      endfunction

      function void push_item(logic [1:0] kind, logic [2:0] fld, logic [7:0] data,
                              logic [1:0] status);
         rsp_word_type w;
         w.item_kind   = kind;
         w.field_id    = fld;
         w.data_byte   = data;
         w.status_code = status;
         w.run_end     = 1'b0;
         burst.push_back(w);
      endfunction

      function void match_key_char(logic [7:0] c);
         for (int i = 0; i < 5; i++) begin
            if (kflags[i]) begin
               if (int'(klen) >= key_size(i)) kflags[i] = 1'b0;
               else if (key_char(i, int'(klen)) != c) kflags[i] = 1'b0;
            end
         end
         if (klen != 5'd31) klen++;
      endfunction

      function void deliver(logic [7:0] c, bit in_value);
         if (!in_value) begin
            match_key_char(c);
         end else if (field < NoField) begin
            push_item(KindData, field, c, StatusOk);
            if (field == FieldPlace) place_filled = 1'b1;
         end
      endfunction

      function void take_char(logic [7:0] b, bit in_value);
         int hi, lo;
         case (esc_state)
            2'd0: begin
               if (b == ChPct) esc_state = 2'd1;
               else deliver(b == ChPlus ? ChSpace : b, in_value);
            end
            2'd1: begin
               esc_first = b;
               esc_state = 2'd2;
            end
            default: begin
               hi = hex_digit(esc_first);
               lo = hex_digit(b);
               if (hi >= 0 && lo >= 0) deliver(8'(hi * 16 + lo), in_value);
               else if (in_value) err = StatusBadEscape;
               else key_bad = 1'b1;
               esc_state = '0;
               esc_first = '0;
            end
         endcase
      endfunction

      function void flush_escape(bit in_value);
         if (esc_state >= 2'd1) deliver(ChPct, in_value);
         if (esc_state == 2'd2) deliver(esc_first == ChPlus ? ChSpace : esc_first, in_value);
         esc_state = '0;
         esc_first = '0;
      endfunction

      function void scheme_step(logic [7:0] b);
         logic ok;
         if (spos == PrefixPivot) begin
            ok = 1'b1;
            if (b == ChColon) variant = 1'b0;
            else if (b == ChDash) variant = 1'b1;
            else ok = 1'b0;
         end else begin
            ok = int'(spos) < scheme_len(variant) && scheme_char(variant, int'(spos)) == b;
         end
         if (!ok) begin
            phase = PH_REJECT;
         end else begin
            spos++;
            if (int'(spos) >= scheme_len(variant)) start_pair();
         end
      endfunction

      function void commit_key();
         flush_escape(1'b0);
         if (key_bad) err = StatusBadEscape;
         field = NoField;
         for (int i = 0; i < 5; i++)
            if (kflags[i] && int'(klen) == key_size(i)) field = 3'(i);
         if (field < NoField) begin
            push_item(KindStart, field, '0, StatusOk);
            if (field == FieldPlace) place_filled = 1'b0;
         end
         phase     = PH_VALUE;
         esc_state = '0;
         esc_first = '0;
      endfunction

      // accepted input word: predict the words it produces
      function void note_byte(req_word_type w);
         logic [7:0]   b;
         logic [1:0]   status;
         rsp_word_type r;
         b = w.uri_byte;
         burst.delete();
         case (phase)
            PH_SCHEME: scheme_step(b);
            PH_KEY: begin
               if (b == ChAmp) start_pair();
               else if (b == ChEq) commit_key();
               else take_char(b, 1'b0);
            end
            PH_VALUE: begin
               if (b == ChAmp) begin
                  flush_escape(1'b1);
                  start_pair();
               end else begin
                  take_char(b, 1'b1);
               end
            end
            default: ;
         endcase
         if (w.is_final) begin
            if (phase == PH_VALUE) flush_escape(1'b1);
            if (phase == PH_SCHEME || phase == PH_REJECT) status = StatusBadScheme;
            else if (err != StatusOk) status = StatusBadEscape;
            else if (!place_filled) status = StatusNoPlace;
            else status = StatusOk;
            push_item(KindStatus, '0, '0, status);
            clear_state();
         end
         foreach (burst[i]) begin
            r = burst[i];
            r.run_end = (i == burst.size() - 1);
            due_words.push_back(r);
         end
      endfunction

      function void report(string what, rsp_word_type want, rsp_word_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected kind %0d field %0d data %h status %0d end %0d, got kind %0d field %0d data %h status %0d end %0d",
                     what, want.item_kind, want.field_id, want.data_byte, want.status_code,
                     want.run_end, got.item_kind, got.field_id, got.data_byte,
                     got.status_code, got.run_end);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (due_words.size() == 0) begin
            report("unexpected word", '0, got);
            return;
         end
         want = due_words.pop_front();
         if (want.item_kind != got.item_kind || want.field_id != got.field_id ||
             want.data_byte != got.data_byte || want.status_code != got.status_code ||
             want.run_end != got.run_end)
            report("wrong word", want, got);
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      function void close();
         if (due_words.size() != 0) begin
            mismatches++;
            $display("%0d expected words never arrived", due_words.size());
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   req_word_type req_word = '0;
   logic         req_stall;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         rsp_stall = 1'b0;

   query_scoreboard sb;
   logic [7:0]      uri[$];
   int              send_idle = 23;
   int              recv_idle = 66;
   int              cycle_count = 0;

   launch_query_parser_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("launch_query_parser_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_word);
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
   end

   task automatic send_word(input req_word_type w);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_byte(w);
   endtask

   task automatic send_uri();
      req_word_type w;
      foreach (uri[i]) begin
         w.uri_byte = uri[i];
         w.is_final = (i == uri.size() - 1);
         send_word(w);
      end
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) uri.push_back(s[i]);
   endtask

   function automatic logic [7:0] hex_char(int n);
      if (n < 10) return 8'(8'h30 + n);
      return $urandom_range(0, 1) ? 8'(8'h41 + n - 10) : 8'(8'h61 + n - 10);
   endfunction

   function automatic logic [7:0] letter();
      return 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   function automatic logic [7:0] junk_char();
      case ($urandom_range(0, 5))
         0: return ChPct;
         1: return ChPlus;
         2: return 8'($urandom_range(0, 255));
         default: return letter();
      endcase
   endfunction

   task automatic add_escape(logic [7:0] value);
      uri.push_back(ChPct);
      uri.push_back(hex_char(int'(value[7:4])));
      uri.push_back(hex_char(int'(value[3:0])));
   endtask

   task automatic add_bad_escape();
      logic [7:0] a, b;
      a = 8'($urandom_range(8'h67, 8'h7A));
      b = hex_char($urandom_range(0, 15));
      uri.push_back(ChPct);
      if ($urandom_range(0, 1)) begin
         uri.push_back(a);
         uri.push_back($urandom_range(0, 1) ? b : letter());
      end else begin
         uri.push_back(b);
         uri.push_back(a);
      end
   endtask

   task automatic add_key();
      int         idx, len, tweak, at;
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) begin
         len = $urandom_range(0, 4);
         for (int i = 0; i < len; i++) uri.push_back(junk_char());
         if ($urandom_range(0, 4) == 0) add_bad_escape();
      end else begin
         idx   = $urandom_range(0, 4);
         len   = sb.key_size(idx);
         tweak = $urandom_range(0, 9);
         at    = $urandom_range(0, len - 1);
         for (int i = 0; i < len; i++) begin
            c = sb.key_char(idx, i);
            if (i == at && tweak == 0) add_escape(c);
            else if (i == at && tweak == 1) uri.push_back(c ^ 8'h20);
            else if (!(tweak == 3 && i == len - 1)) uri.push_back(c);
         end
         if (tweak == 2) uri.push_back(junk_char());
      end
   endtask

   task automatic add_value();
      int n;
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: uri.push_back(ChPlus);
            1: uri.push_back(ChEq);
            2, 3: add_escape(8'($urandom_range(0, 255)));
            4: add_bad_escape();
            5: begin
               // trailing escape that the pair ends before completing
               uri.push_back(ChPct);
               if ($urandom_range(0, 1)) uri.push_back($urandom_range(0, 2) ? letter() : ChPlus);
               break;
            end
            6: uri.push_back(8'($urandom_range(0, 255)));
            default: uri.push_back(letter());
         endcase
      end
   endtask

   task automatic build_uri();
      int         mode, pairs, v, len, cut, n;
      logic [7:0] c;
      uri.delete();
      mode = $urandom_range(0, 19);
      v    = $urandom_range(0, 1);
      len  = sb.scheme_len(v);
      if (mode < 16) begin
         for (int i = 0; i < len; i++) uri.push_back(sb.scheme_char(v, i));
         pairs = $urandom_range(0, 3);
         for (int p = 0; p < pairs; p++) begin
            if (p > 0) uri.push_back(ChAmp);
            if ($urandom_range(0, 9) == 0) uri.push_back(ChAmp);
            add_key();
            if ($urandom_range(0, 6) != 0) begin
               uri.push_back(ChEq);
               add_value();
            end
         end
      end else if (mode < 19) begin
         cut = $urandom_range(1, len);
         for (int i = 0; i < cut; i++) begin
            c = sb.scheme_char(v, i);
            if (i == cut - 1 && $urandom_range(0, 1)) c = c ^ 8'h01;
            uri.push_back(c);
         end
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) uri.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) uri.push_back(8'($urandom_range(0, 255)));
      end
      if (uri.size() == 0) uri.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int sent;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single-byte URIs at both ends of the byte range
      uri.delete();
      uri.push_back(8'h00);
      send_uri();
      uri.delete();
      uri.push_back(8'hFF);
      send_uri();
      // place id whose value ends in an unfinished escape
      uri.delete();
      for (int i = 0; i < sb.scheme_len(0); i++) uri.push_back(sb.scheme_char(0, i));
      add_text("placeId=%4");
      send_uri();

      sent = 0;
      while (sent < RandomBytes) begin
         if (sent >= 2 * RandomBytes / 3) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (sent >= RandomBytes / 3) begin
            send_idle = 66;
            recv_idle = 23;
         end
         build_uri();
         send_uri();
         sent += uri.size();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      sb.close();
      if (sb.mismatches == 0) $display("launch_query_parser_core: match");
      else $display("launch_query_parser_core: mismatch");
      $finish;
   end

endmodule

FILE: launch_query_parser_core.f
+incdir+src
src/lqp_pkg.sv
src/lqp_front.sv
src/lqp_queue.sv
src/lqp_back.sv
src/launch_query_parser_core.sv
sim/testbench.sv
